### rtl/v3n_pkg.sv
// Shared constants and types for the 3D vector normalizer.
`default_nettype none
package v3n_pkg;

  localparam int COMPONENT_BITS_DEF = 32;
  localparam int FRACTION_BITS_DEF  = 16;

  // pipeline advance and the valid bit of the word entering a section
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

### rtl/v3n_if.sv
// Valid/ready channel interfaces for vector input words and unit vector output words.
`default_nettype none
interface v3n_in_if #(
  parameter int CB = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] comp_x;
  logic signed [CB-1:0] comp_y;
  logic signed [CB-1:0] comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3n_out_if #(
  parameter int UB = 18
);
  logic                 valid;
  logic                 ready;
  logic signed [UB-1:0] unit_x;
  logic signed [UB-1:0] unit_y;
  logic signed [UB-1:0] unit_z;
  logic                 zero_input;

  modport source (output valid, unit_x, unit_y, unit_z, zero_input, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_input, output ready);
endinterface
`default_nettype wire

### rtl/v3n_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband carried along.
`default_nettype none
module v3n_isqrt
  import v3n_pkg::*;
#(
  parameter int N  = 32,
  parameter int SW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pipe_ctrl_t     ctrl,
  input  wire logic [2*N-1:0] sum,
  input  wire logic [SW-1:0]  side_in,
  output logic                valid,
  output logic [N-1:0]        root,
  output logic [SW-1:0]       side_out
);

  logic [N:0]     rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] sum_q  [N];
  logic [SW-1:0]  side_q [N];
  logic           vld_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N:0]     rem_s;
    logic [N-1:0]   root_s;
    logic [2*N-1:0] sum_s;
    logic [SW-1:0]  side_s;
    logic           vld_s;
    logic [N+2:0]   cand;
    logic [N+2:0]   trial;
    logic [N+2:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign sum_s  = sum;
      assign side_s = side_in;
      assign vld_s  = ctrl.valid;
    end else begin : g_rest
      assign rem_s  = rem_q[i-1];
      assign root_s = root_q[i-1];
      assign sum_s  = sum_q[i-1];
      assign side_s = side_q[i-1];
      assign vld_s  = vld_q[i-1];
    end

    // bring down the next two bits of the radicand
    assign cand  = {rem_s, sum_s[2*N-1-2*i -: 2]};
    assign trial = {1'b0, root_s, 2'b01};
    assign ge    = cand >= trial;
    assign diff  = cand - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (ctrl.en) begin
        vld_q[i] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        rem_q[i]  <= ge ? diff[N:0] : cand[N:0];
        root_q[i] <= {root_s[N-2:0], ge};
        sum_q[i]  <= sum_s;
        side_q[i] <= side_s;
      end
    end
  end

  assign valid    = vld_q[N-1];
  assign root     = root_q[N-1];
  assign side_out = side_q[N-1];

endmodule
`default_nettype wire

### rtl/v3n_div.sv
// Pipelined restoring divider: three quotients mag*2^FB/len, one quotient bit per stage.
`default_nettype none
module v3n_div
  import v3n_pkg::*;
#(
  parameter int N  = 32,
  parameter int FB = 16,
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pipe_ctrl_t    ctrl,
  input  wire logic [N-1:0]  len,
  input  wire logic [N-1:0]  mag_x,
  input  wire logic [N-1:0]  mag_y,
  input  wire logic [N-1:0]  mag_z,
  input  wire logic [SW-1:0] side_in,
  output logic               valid,
  output logic [FB:0]        quo_x,
  output logic [FB:0]        quo_y,
  output logic [FB:0]        quo_z,
  output logic [SW-1:0]      side_out
);

  localparam int NQ = FB + 1;

  logic [N-1:0]  rem_q  [NQ][3];
  logic [FB:0]   quo_q  [NQ][3];
  logic [N-1:0]  len_q  [NQ];
  logic [SW-1:0] side_q [NQ];
  logic          vld_q  [NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_stage
    logic [N-1:0]  len_s;
    logic [SW-1:0] side_s;
    logic          vld_s;
    logic [N:0]    part [3];
    logic [FB:0]   quo_s [3];

    if (j == 0) begin : g_first
      assign len_s  = len;
      assign side_s = side_in;
      assign vld_s  = ctrl.valid;
      // mag <= len, so the leading quotient bit is the only one above the point
      assign part[0]  = {1'b0, mag_x};
      assign part[1]  = {1'b0, mag_y};
      assign part[2]  = {1'b0, mag_z};
      assign quo_s[0] = '0;
      assign quo_s[1] = '0;
      assign quo_s[2] = '0;
    end else begin : g_rest
      assign len_s  = len_q[j-1];
      assign side_s = side_q[j-1];
      assign vld_s  = vld_q[j-1];
      for (genvar c = 0; c < 3; c++) begin : g_shift
        assign part[c]  = {rem_q[j-1][c], 1'b0};
        assign quo_s[c] = quo_q[j-1][c];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (ctrl.en) begin
        vld_q[j] <= vld_s;
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
      logic       ge;
      logic [N:0] diff;
      assign ge   = part[c] >= {1'b0, len_s};
      assign diff = part[c] - {1'b0, len_s};

      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          rem_q[j][c] <= ge ? diff[N-1:0] : part[c][N-1:0];
          quo_q[j][c] <= {quo_s[c][FB-1:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        len_q[j]  <= len_s;
        side_q[j] <= side_s;
      end
    end
  end

  assign valid    = vld_q[NQ-1];
  assign quo_x    = quo_q[NQ-1][0];
  assign quo_y    = quo_q[NQ-1][1];
  assign quo_z    = quo_q[NQ-1][2];
  assign side_out = side_q[NQ-1];

endmodule
`default_nettype wire

### rtl/vector3_normalize_top.sv
// Top level of the 3D vector normalizer.
// Takes one vector word per cycle while the output is not stalled and returns its unit
// vector with FB fraction bits in FB+2 bits, each component truncated toward zero;
// an all-zero vector comes out as zero with zero_input set. The pipeline depth is
// set mostly by the
// one-bit-per-stage square root and the one-bit-per-stage dividers. The whole
// pipeline holds while the output word waits, so a stall loses nothing.
`default_nettype none
module vector3_normalize_top
  import v3n_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  v3n_in_if.sink    vec,
  v3n_out_if.source unit
);

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int UB = FB + 2;
  localparam int NS = $clog2(CB - 1);
  localparam int SW = 3 * CB + 4;

  logic en;
  assign en        = !unit.valid || unit.ready;
  assign vec.ready = en;

  // stage 0: magnitudes and signs
  logic [CB-1:0] mag0 [3];
  logic [2:0]    sgn0;
  logic          vld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn0    <= {vec.comp_z[CB-1], vec.comp_y[CB-1], vec.comp_x[CB-1]};
      mag0[0] <= vec.comp_x[CB-1] ? CB'(-vec.comp_x) : CB'(vec.comp_x);
      mag0[1] <= vec.comp_y[CB-1] ? CB'(-vec.comp_y) : CB'(vec.comp_y);
      mag0[2] <= vec.comp_z[CB-1] ? CB'(-vec.comp_z) : CB'(vec.comp_z);
    end
  end

  // stage 1: largest magnitude
  logic [CB-1:0] mag1 [3];
  logic [CB-1:0] max1;
  logic [2:0]    sgn1;
  logic          vld1;
  logic [CB-1:0] max_xy;
  logic [CB-1:0] max_all;

  assign max_xy  = (mag0[0] > mag0[1]) ? mag0[0] : mag0[1];
  assign max_all = (max_xy > mag0[2]) ? max_xy : mag0[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag0;
      max1 <= max_all;
      sgn1 <= sgn0;
    end
  end

  // normalize stages: shift all three by a power of two while the max stays below the top bit
  logic [CB-1:0] nmag [NS][3];
  logic [CB-1:0] nmax [NS];
  logic [2:0]    nsgn [NS];
  logic          nzero [NS];
  logic          nvld [NS];

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - j);
    logic [CB-1:0] mag_s [3];
    logic [CB-1:0] max_s;
    logic [2:0]    sgn_s;
    logic          zero_s;
    logic          vld_s;
    logic          do_shift;

    if (j == 0) begin : g_first
      assign mag_s  = mag1;
      assign max_s  = max1;
      assign sgn_s  = sgn1;
      assign zero_s = (max1 == '0);
      assign vld_s  = vld1;
    end else begin : g_rest
      assign mag_s  = nmag[j-1];
      assign max_s  = nmax[j-1];
      assign sgn_s  = nsgn[j-1];
      assign zero_s = nzero[j-1];
      assign vld_s  = nvld[j-1];
    end

    assign do_shift = (max_s >> (CB - 1 - SH)) == '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        nvld[j] <= 1'b0;
      end else if (en) begin
        nvld[j] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nmax[j]  <= do_shift ? (max_s << SH) : max_s;
        for (int c = 0; c < 3; c++) begin
          nmag[j][c] <= do_shift ? (mag_s[c] << SH) : mag_s[c];
        end
        nsgn[j]  <= sgn_s;
        nzero[j] <= zero_s;
      end
    end
  end

  // squares
  logic [2*CB-1:0] sq [3];
  logic [CB-1:0]   mag_sq [3];
  logic [2:0]      sgn_sq;
  logic            zero_sq;
  logic            vld_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sq <= 1'b0;
    end else if (en) begin
      vld_sq <= nvld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq[c] <= nmag[NS-1][c] * nmag[NS-1][c];
      end
      mag_sq  <= nmag[NS-1];
      sgn_sq  <= nsgn[NS-1];
      zero_sq <= nzero[NS-1];
    end
  end

  // sum of squares; it fits 2*CB bits since every scaled magnitude is at most 2^(CB-1)
  logic [2*CB-1:0] sum;
  logic [SW-1:0]   side_sum;
  logic            vld_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sum <= 1'b0;
    end else if (en) begin
      vld_sum <= vld_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= sq[0] + sq[1] + sq[2];
      side_sum <= {zero_sq, sgn_sq, mag_sq[2], mag_sq[1], mag_sq[0]};
    end
  end

  pipe_ctrl_t    sqrt_ctrl;
  logic          vld_rt;
  logic [CB-1:0] len;
  logic [SW-1:0] side_rt;

  assign sqrt_ctrl = '{en: en, valid: vld_sum};

  v3n_isqrt #(
    .N  (CB),
    .SW (SW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sqrt_ctrl),
    .sum      (sum),
    .side_in  (side_sum),
    .valid    (vld_rt),
    .root     (len),
    .side_out (side_rt)
  );

  pipe_ctrl_t div_ctrl;
  logic       vld_dv;
  logic [FB:0] quo [3];
  logic [3:0]  side_dv;

  assign div_ctrl = '{en: en, valid: vld_rt};

  v3n_div #(
    .N  (CB),
    .FB (FB),
    .SW (4)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .len      (len),
    .mag_x    (side_rt[CB-1:0]),
    .mag_y    (side_rt[2*CB-1:CB]),
    .mag_z    (side_rt[3*CB-1:2*CB]),
    .side_in  (side_rt[SW-1:3*CB]),
    .valid    (vld_dv),
    .quo_x    (quo[0]),
    .quo_y    (quo[1]),
    .quo_z    (quo[2]),
    .side_out (side_dv)
  );

  // output word: apply signs; a zero vector divides by zero upstream, so force it to zero
  logic [UB-1:0] res [3];

  for (genvar c = 0; c < 3; c++) begin : g_sign
    logic [UB-1:0] q_ext;
    assign q_ext  = {1'b0, quo[c]};
    assign res[c] = side_dv[3] ? '0 : (side_dv[c] ? (~q_ext + 1'b1) : q_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit.valid <= 1'b0;
    end else if (en) begin
      unit.valid <= vld_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit.unit_x     <= res[0];
      unit.unit_y     <= res[1];
      unit.unit_z     <= res[2];
      unit.zero_input <= side_dv[3];
    end
  end

endmodule
`default_nettype wire

### verif/vector3_normalize_checker.sv
// Checker for the 3D vector normalizer: predicts unit vectors and compares output words.
module vector3_normalize_checker #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  v3n_in_if.sink    vec,
  v3n_out_if.sink   unit,
  output int        fail_count,
  output int        pending
);
  localparam int UB = FB + 2;

  typedef struct packed {
    logic signed [UB-1:0] ux;
    logic signed [UB-1:0] uy;
    logic signed [UB-1:0] uz;
    logic                 zero;
  } unit_word_t;

  unit_word_t expected_units[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic unit_word_t normalize(input logic signed [CB-1:0] x,
                                           input logic signed [CB-1:0] y,
                                           input logic signed [CB-1:0] z);
    logic signed [CB-1:0] comp[3];
    logic [63:0] mag[3];
    logic [63:0] peak;
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] quo;
    logic [UB-1:0] res[3];
    unit_word_t w;
    comp[0] = x; comp[1] = y; comp[2] = z;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][CB-1] ? 64'(-$signed(65'(comp[i]))) : 64'(comp[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      w = '0;
      w.zero = 1'b1;
      return w;
    end
    while (peak < (64'd1 << (CB - 2))) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      quo = (mag[i] << FB) / len;
      res[i] = comp[i][CB-1] ? UB'(-quo) : UB'(quo);
    end
    w.ux = res[0]; w.uy = res[1]; w.uz = res[2]; w.zero = 1'b0;
    return w;
  endfunction

  assign pending = expected_units.size();

  always @(posedge clk) begin
    unit_word_t want;
    unit_word_t got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (vec.valid && vec.ready)
        expected_units.push_back(normalize(vec.comp_x, vec.comp_y, vec.comp_z));
      if (unit.valid && unit.ready) begin
        got = {unit.unit_x, unit.unit_y, unit.unit_z, unit.zero_input};
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_units.pop_front();
          if (got.ux !== want.ux || got.uy !== want.uy || got.uz !== want.uz ||
              got.zero !== want.zero) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d zero=%b actual x=%0d y=%0d z=%0d zero=%b",
                     $time, want.ux, want.uy, want.uz, want.zero,
                     got.ux, got.uy, got.uz, got.zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/testbench.sv
// Top of the 3D vector normalizer testbench: stimulus, output stalls and verdict.
module testbench;
  import v3n_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int LATENCY = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  v3n_in_if  #(.CB(CB))     vec();
  v3n_out_if #(.UB(FB + 2)) unit();

  always #1 clk = ~clk;

  vector3_normalize_top #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst), .vec(vec), .unit(unit)
  );

  vector3_normalize_checker #(.CB(CB), .FB(FB)) checker_i (
    .clk(clk), .rst(rst), .vec(vec), .unit(unit),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    vec.valid  = 1'b0;
    vec.comp_x = '0;
    vec.comp_y = '0;
    vec.comp_z = '0;
    unit.ready = 1'b0;
  end

  // receiver stall pattern: alternating modes of full speed, sparse and random
  always @(posedge clk) begin
    int mode;
    mode = ($time / 4000) % 3;
    if (rst) unit.ready <= 1'b0;
    else if (mode == 0) unit.ready <= 1'b1;
    else if (mode == 1) unit.ready <= ($urandom_range(0, 7) == 0);
    else unit.ready <= $urandom_range(0, 1);
  end

  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 3);
      1: return -$urandom_range(1, 3);
      2: return {1'b1, {(CB-1){1'b0}}};
      3: return {1'b0, {(CB-1){1'b1}}};
      4: return $signed($urandom) >>> $urandom_range(0, CB - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [CB-1:0] x, input logic [CB-1:0] y,
                           input logic [CB-1:0] z);
    vec.valid  <= 1'b1;
    vec.comp_x <= x;
    vec.comp_y <= y;
    vec.comp_z <= z;
    @(posedge clk);
    while (!vec.ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      vec.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [CB-1:0] mn;
    logic [CB-1:0] mx;
    logic [CB-1:0] one;
    int burst;
    int sent;
    int waited;
    mn  = {1'b1, {(CB-1){1'b0}}};
    mx  = {1'b0, {(CB-1){1'b1}}};
    one = 1 << FB;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axes, extremes of each component
    send_word(0, 0, 0);
    send_word(one, 0, 0);
    send_word(0, -one, 0);
    send_word(0, 0, one);
    send_word(1, 0, 0);
    send_word(0, 0, -1);
    send_word(mn, 0, 0);
    send_word(0, mn, 0);
    send_word(0, 0, mx);
    send_word(mn, mn, mn);
    send_word(mx, mx, mx);
    send_word(mn, mx, mn);
    send_word(mx, mn, 1);
    send_word(1, 1, 1);
    send_word(-1, -1, -1);
    send_word(3 * one, 4 * one, 0);
    send_word(-1, 2, -2);
    send_word('1, 0, 1);
    idle_gap();

    sent = 0;
    while (sent < 2000) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_word(rand_comp(), rand_comp(), rand_comp());
      sent += burst;
      idle_gap();
    end
    vec.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[vector3_normalize_top] OK");
    else $display("[vector3_normalize_top] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[vector3_normalize_top] ERROR");
    $finish;
  end
endmodule

### vector3_normalize_top.f
rtl/v3n_pkg.sv
rtl/v3n_if.sv
rtl/v3n_isqrt.sv
rtl/v3n_div.sv
rtl/vector3_normalize_top.sv
verif/vector3_normalize_checker.sv
verif/testbench.sv
